// ----- design/aisd_pkg.sv -----
// aisd_pkg: shared types, kind codes and the ordered form table of the a64 subset decoder
// depends on nothing; imported by aarch64_subset_instruction_decoder and tb_aarch64_subset_instruction_decoder
`timescale 1ns / 1ps
`default_nettype none

package aisd_pkg;

    localparam int NUM_FORMS  = 35;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 6;
    localparam int REG_W      = 5;
    localparam int PRIM_W     = 21;
    localparam int SEC_W      = 6;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  form_idx_t;
    typedef logic [NUM_FORMS-1:0] hit_vec_t;

    typedef struct packed {
        logic ccl;
        logic cch;
        logic ex;
        logic sh;
        logic ra;
        logic rm;
        logic rn;
        logic rd;
    } use_t;

    typedef enum logic [2:0] {
        P_NONE  = 3'd0,
        P_IMM12 = 3'd1,
        P_AMT6  = 3'd2,
        P_IMM16 = 3'd3,
        P_SIMM9 = 3'd4,
        P_IMMR  = 3'd5,
        P_BR    = 3'd6
    } prim_kind_t;

    typedef enum logic [2:0] {
        S_NONE    = 3'd0,
        S_SH12    = 3'd1,
        S_HW16    = 3'd2,
        S_IMMS    = 3'd3,
        S_BIT12X2 = 3'd4,
        S_BIT12X3 = 3'd5,
        S_BIT12X1 = 3'd6,
        S_EXT3    = 3'd7
    } sec_kind_t;

    typedef struct packed {
        word_t      mask;
        word_t      value;
        use_t       uses;
        prim_kind_t pkind;
        sec_kind_t  skind;
    } form_t;

    // use bit order: ccl cch ex sh ra rm rn rd
    localparam use_t U_RD  = use_t'(8'b0000_0001);
    localparam use_t U_RN  = use_t'(8'b0000_0010);
    localparam use_t U_ARI = use_t'(8'b0000_0011);
    localparam use_t U_SHR = use_t'(8'b0001_0111);
    localparam use_t U_CSL = use_t'(8'b0100_0111);
    localparam use_t U_MAD = use_t'(8'b0000_1111);
    localparam use_t U_LSR = use_t'(8'b0010_0111);
    localparam use_t U_RRR = use_t'(8'b0000_0111);
    localparam use_t U_CCL = use_t'(8'b1000_0000);

    localparam form_t FORMS [NUM_FORMS] = '{
        '{32'hff000000, 32'h91000000, U_ARI, P_IMM12, S_SH12},
        '{32'hff000000, 32'hd1000000, U_ARI, P_IMM12, S_SH12},
        '{32'hff200000, 32'h8b000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h0b000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h4b000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h6b000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h0a000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h2a000000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h2a200000, U_SHR, P_AMT6,  S_NONE},
        '{32'hff800000, 32'h72800000, U_RD,  P_IMM16, S_HW16},
        '{32'hff800000, 32'h52800000, U_RD,  P_IMM16, S_HW16},
        '{32'hff800000, 32'hd2800000, U_RD,  P_IMM16, S_HW16},
        '{32'hffe00c00, 32'h1a800000, U_CSL, P_NONE,  S_NONE},
        '{32'hffe00c00, 32'h9a800000, U_CSL, P_NONE,  S_NONE},
        '{32'hffe00c00, 32'h5a800000, U_CSL, P_NONE,  S_NONE},
        '{32'hffe08000, 32'h1b000000, U_MAD, P_NONE,  S_NONE},
        '{32'hffe08000, 32'h9b200000, U_MAD, P_NONE,  S_NONE},
        '{32'hffe04c00, 32'hb8604800, U_LSR, P_NONE,  S_BIT12X2},
        '{32'hffe04c00, 32'hb8204800, U_LSR, P_NONE,  S_BIT12X2},
        '{32'hffe04c00, 32'hf8604800, U_LSR, P_NONE,  S_BIT12X3},
        '{32'hffe04c00, 32'hf8204800, U_LSR, P_NONE,  S_BIT12X3},
        '{32'hffe04c00, 32'h38604800, U_LSR, P_NONE,  S_NONE},
        '{32'hffe04c00, 32'h38204800, U_LSR, P_NONE,  S_NONE},
        '{32'hffe04c00, 32'h78604800, U_LSR, P_NONE,  S_BIT12X1},
        '{32'hffe04c00, 32'h78204800, U_LSR, P_NONE,  S_BIT12X1},
        '{32'hffe00c00, 32'hb8400400, U_ARI, P_SIMM9, S_NONE},
        '{32'hffe00c00, 32'hb8000c00, U_ARI, P_SIMM9, S_NONE},
        '{32'hffc00000, 32'h13000000, U_ARI, P_IMMR,  S_IMMS},
        '{32'hffc00000, 32'h53000000, U_ARI, P_IMMR,  S_IMMS},
        '{32'hffc00000, 32'hd3400000, U_ARI, P_IMMR,  S_IMMS},
        '{32'hffe00000, 32'h13800000, U_RRR, P_AMT6,  S_NONE},
        '{32'hff000000, 32'h54000000, U_CCL, P_BR,    S_NONE},
        '{32'hfffffc1f, 32'hd65f0000, U_RN,  P_NONE,  S_NONE},
        '{32'hffe00000, 32'h8b200000, U_LSR, P_NONE,  S_EXT3},
        '{32'hffe00000, 32'hcb200000, U_LSR, P_NONE,  S_EXT3}
    };

endpackage

`default_nettype wire

// ----- design/aarch64_subset_instruction_decoder.sv -----
// aarch64_subset_instruction_decoder: three-stage pipelined a64 subset decoder
// depends on aisd_pkg (form table, kind codes, types)
//
// channel   ports                                  handshake
// command   instr_word                             start, busy (always low)
// result    matched form_index ... secondary_imm   done, one-cycle strobe
//
// a transaction's result passes through the stage 1, stage 2 and output registers
// before its done strobe; one transaction per cycle sustained
// stage 1 compares against all forms, stage 2 priority-encodes the first hit,
// stage 3 looks the form up and extracts fields into the output registers
// reset clears the stage valid bits only; the receiver cannot stall, so
// nothing holds and busy stays low
`timescale 1ns / 1ps
`default_nettype none

module aarch64_subset_instruction_decoder
    import aisd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [WORD_W-1:0]        instr_word,
    output logic                          done,
    output logic                          matched,
    output logic [IDX_W-1:0]              form_index,
    output logic [REG_W-1:0]              dest_reg,
    output logic [REG_W-1:0]              first_src_reg,
    output logic [REG_W-1:0]              second_src_reg,
    output logic [REG_W-1:0]              addend_reg,
    output logic [1:0]                    shift_type,
    output logic [2:0]                    extend_option,
    output logic [3:0]                    cond_code,
    output logic signed [PRIM_W-1:0]      primary_imm,
    output logic [SEC_W-1:0]              secondary_imm
);

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    word_t      s1_word_reg, s2_word_reg;
    hit_vec_t   s1_hit_reg, s1_hit_next;
    logic       s2_matched_reg, s2_matched_next;
    form_idx_t  s2_index_reg, s2_index_next;

    logic                     matched_reg;
    form_idx_t                form_index_reg, form_index_next;
    logic [REG_W-1:0]         dest_reg_reg, dest_reg_next;
    logic [REG_W-1:0]         first_src_reg_reg, first_src_reg_next;
    logic [REG_W-1:0]         second_src_reg_reg, second_src_reg_next;
    logic [REG_W-1:0]         addend_reg_reg, addend_reg_next;
    logic [1:0]               shift_type_reg, shift_type_next;
    logic [2:0]               extend_option_reg, extend_option_next;
    logic [3:0]               cond_code_reg, cond_code_next;
    logic [PRIM_W-1:0]        primary_imm_reg, primary_imm_next;
    logic [SEC_W-1:0]         secondary_imm_reg, secondary_imm_next;

    form_t      s2_form;
    logic [3:0] sec_mult;

    assign busy = 1'b0;

    // stage 1: parallel mask compares
    always_comb
    begin
        for (int i = 0; i < NUM_FORMS; i++)
        begin
            s1_hit_next[i] = ((instr_word & FORMS[i].mask) == FORMS[i].value);
        end
    end

    // stage 2: first hit wins
    always_comb
    begin
        s2_matched_next = |s1_hit_reg;
        s2_index_next   = '0;
        for (int i = NUM_FORMS - 1; i >= 0; i--)
        begin
            if (s1_hit_reg[i])
            begin
                s2_index_next = IDX_W'(i);
            end
        end
    end

    // stage 3: form lookup and field extraction
    assign s2_form = FORMS[s2_index_reg];

    always_comb
    begin
        sec_mult = 4'd0;
        unique case (s2_form.skind)
            S_SH12:    sec_mult = 4'd12;
            S_HW16:    sec_mult = 4'd0;
            S_BIT12X2: sec_mult = 4'd2;
            S_BIT12X3: sec_mult = 4'd3;
            S_BIT12X1: sec_mult = 4'd1;
            default:   sec_mult = 4'd0;
        endcase
    end

    always_comb
    begin
        form_index_next     = '0;
        dest_reg_next       = '0;
        first_src_reg_next  = '0;
        second_src_reg_next = '0;
        addend_reg_next     = '0;
        shift_type_next     = '0;
        extend_option_next  = '0;
        cond_code_next      = '0;
        primary_imm_next    = '0;
        secondary_imm_next  = '0;
        if (s2_matched_reg)
        begin
            form_index_next = s2_index_reg;
            if (s2_form.uses.rd) dest_reg_next       = s2_word_reg[4:0];
            if (s2_form.uses.rn) first_src_reg_next  = s2_word_reg[9:5];
            if (s2_form.uses.rm) second_src_reg_next = s2_word_reg[20:16];
            if (s2_form.uses.ra) addend_reg_next     = s2_word_reg[14:10];
            if (s2_form.uses.sh) shift_type_next     = s2_word_reg[23:22];
            if (s2_form.uses.ex) extend_option_next  = s2_word_reg[15:13];
            if (s2_form.uses.cch)
            begin
                cond_code_next = s2_word_reg[15:12];
            end
            else if (s2_form.uses.ccl)
            begin
                cond_code_next = s2_word_reg[3:0];
            end

            unique case (s2_form.pkind)
                P_IMM12: primary_imm_next = PRIM_W'(s2_word_reg[21:10]);
                P_AMT6:  primary_imm_next = PRIM_W'(s2_word_reg[15:10]);
                P_IMM16: primary_imm_next = PRIM_W'(s2_word_reg[20:5]);
                P_SIMM9: primary_imm_next = {{(PRIM_W-9){s2_word_reg[20]}},
                                             s2_word_reg[20:12]};
                P_IMMR:  primary_imm_next = PRIM_W'(s2_word_reg[21:16]);
                P_BR:    primary_imm_next = {s2_word_reg[23:5], 2'b00};
                default: primary_imm_next = '0;
            endcase

            unique case (s2_form.skind)
                S_SH12:    secondary_imm_next = SEC_W'(s2_word_reg[23:22]) * SEC_W'(sec_mult);
                S_HW16:    secondary_imm_next = {s2_word_reg[22:21], 4'b0000};
                S_IMMS:    secondary_imm_next = s2_word_reg[15:10];
                S_BIT12X2,
                S_BIT12X3,
                S_BIT12X1: secondary_imm_next = SEC_W'(s2_word_reg[12]) * SEC_W'(sec_mult);
                S_EXT3:    secondary_imm_next = SEC_W'(s2_word_reg[12:10]);
                default:   secondary_imm_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg        <= instr_word;
        s1_hit_reg         <= s1_hit_next;
        s2_word_reg        <= s1_word_reg;
        s2_matched_reg     <= s2_matched_next;
        s2_index_reg       <= s2_index_next;
        matched_reg        <= s2_matched_reg;
        form_index_reg     <= form_index_next;
        dest_reg_reg       <= dest_reg_next;
        first_src_reg_reg  <= first_src_reg_next;
        second_src_reg_reg <= second_src_reg_next;
        addend_reg_reg     <= addend_reg_next;
        shift_type_reg     <= shift_type_next;
        extend_option_reg  <= extend_option_next;
        cond_code_reg      <= cond_code_next;
        primary_imm_reg    <= primary_imm_next;
        secondary_imm_reg  <= secondary_imm_next;
    end

    assign done           = s3_valid_reg;
    assign matched        = matched_reg;
    assign form_index     = form_index_reg;
    assign dest_reg       = dest_reg_reg;
    assign first_src_reg  = first_src_reg_reg;
    assign second_src_reg = second_src_reg_reg;
    assign addend_reg     = addend_reg_reg;
    assign shift_type     = shift_type_reg;
    assign extend_option  = extend_option_reg;
    assign cond_code      = cond_code_reg;
    assign primary_imm    = primary_imm_reg;
    assign secondary_imm  = secondary_imm_reg;

endmodule

`default_nettype wire

// ----- test/tb_aarch64_subset_instruction_decoder.sv -----
// tb_aarch64_subset_instruction_decoder: self-checking testbench for the a64 subset decoder
// drives directed and random instruction words, checks each result against a directed expectation or a local decoder
// depends on aisd_pkg (types, kind codes) and aarch64_subset_instruction_decoder
`timescale 1ns / 1ps

module tb_aarch64_subset_instruction_decoder;
    import aisd_pkg::*;

    typedef struct packed {
        logic                     matched;
        logic [IDX_W-1:0]         form_index;
        logic [REG_W-1:0]         dest_reg;
        logic [REG_W-1:0]         first_src_reg;
        logic [REG_W-1:0]         second_src_reg;
        logic [REG_W-1:0]         addend_reg;
        logic [1:0]               shift_type;
        logic [2:0]               extend_option;
        logic [3:0]               cond_code;
        logic signed [PRIM_W-1:0] primary_imm;
        logic [SEC_W-1:0]         secondary_imm;
    } decode_result_t;

    typedef struct packed {
        word_t      mask;
        word_t      value;
        use_t       uses;
        prim_kind_t pkind;
        sec_kind_t  skind;
    } decode_form_t;

    typedef struct packed {
        word_t          word;
        logic           known;
        decode_result_t want;
    } directed_row_t;

    // field use bits: ccl cch ex sh ra rm rn rd
    localparam use_t USES_RD      = use_t'(8'b0000_0001);
    localparam use_t USES_RN      = use_t'(8'b0000_0010);
    localparam use_t USES_ARITH   = use_t'(8'b0000_0011);
    localparam use_t USES_SHIFTED = use_t'(8'b0001_0111);
    localparam use_t USES_CSEL    = use_t'(8'b0100_0111);
    localparam use_t USES_MADD    = use_t'(8'b0000_1111);
    localparam use_t USES_REGOFF  = use_t'(8'b0010_0111);
    localparam use_t USES_EXTR    = use_t'(8'b0000_0111);
    localparam use_t USES_BCOND   = use_t'(8'b1000_0000);

    localparam decode_form_t FORM_TABLE [NUM_FORMS] = '{
        '{32'hff000000, 32'h91000000, USES_ARITH,   P_IMM12, S_SH12},
        '{32'hff000000, 32'hd1000000, USES_ARITH,   P_IMM12, S_SH12},
        '{32'hff200000, 32'h8b000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h0b000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h4b000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h6b000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h0a000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h2a000000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff200000, 32'h2a200000, USES_SHIFTED, P_AMT6,  S_NONE},
        '{32'hff800000, 32'h72800000, USES_RD,      P_IMM16, S_HW16},
        '{32'hff800000, 32'h52800000, USES_RD,      P_IMM16, S_HW16},
        '{32'hff800000, 32'hd2800000, USES_RD,      P_IMM16, S_HW16},
        '{32'hffe00c00, 32'h1a800000, USES_CSEL,    P_NONE,  S_NONE},
        '{32'hffe00c00, 32'h9a800000, USES_CSEL,    P_NONE,  S_NONE},
        '{32'hffe00c00, 32'h5a800000, USES_CSEL,    P_NONE,  S_NONE},
        '{32'hffe08000, 32'h1b000000, USES_MADD,    P_NONE,  S_NONE},
        '{32'hffe08000, 32'h9b200000, USES_MADD,    P_NONE,  S_NONE},
        '{32'hffe04c00, 32'hb8604800, USES_REGOFF,  P_NONE,  S_BIT12X2},
        '{32'hffe04c00, 32'hb8204800, USES_REGOFF,  P_NONE,  S_BIT12X2},
        '{32'hffe04c00, 32'hf8604800, USES_REGOFF,  P_NONE,  S_BIT12X3},
        '{32'hffe04c00, 32'hf8204800, USES_REGOFF,  P_NONE,  S_BIT12X3},
        '{32'hffe04c00, 32'h38604800, USES_REGOFF,  P_NONE,  S_NONE},
        '{32'hffe04c00, 32'h38204800, USES_REGOFF,  P_NONE,  S_NONE},
        '{32'hffe04c00, 32'h78604800, USES_REGOFF,  P_NONE,  S_BIT12X1},
        '{32'hffe04c00, 32'h78204800, USES_REGOFF,  P_NONE,  S_BIT12X1},
        '{32'hffe00c00, 32'hb8400400, USES_ARITH,   P_SIMM9, S_NONE},
        '{32'hffe00c00, 32'hb8000c00, USES_ARITH,   P_SIMM9, S_NONE},
        '{32'hffc00000, 32'h13000000, USES_ARITH,   P_IMMR,  S_IMMS},
        '{32'hffc00000, 32'h53000000, USES_ARITH,   P_IMMR,  S_IMMS},
        '{32'hffc00000, 32'hd3400000, USES_ARITH,   P_IMMR,  S_IMMS},
        '{32'hffe00000, 32'h13800000, USES_EXTR,    P_AMT6,  S_NONE},
        '{32'hff000000, 32'h54000000, USES_BCOND,   P_BR,    S_NONE},
        '{32'hfffffc1f, 32'hd65f0000, USES_RN,      P_NONE,  S_NONE},
        '{32'hffe00000, 32'h8b200000, USES_REGOFF,  P_NONE,  S_EXT3},
        '{32'hffe00000, 32'hcb200000, USES_REGOFF,  P_NONE,  S_EXT3}
    };

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_WORDS  = 1400;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h00000000, 1'b1, '0},
        '{32'hffffffff, 1'b1, '0},
        '{32'h91ffffff, 1'b1,
          '{1'b1, 6'd0, 5'd31, 5'd31, 5'd0, 5'd0, 2'd0, 3'd0, 4'd0, 21'd4095, 6'd36}},
        '{32'hd1000000, 1'b1,
          '{1'b1, 6'd1, 5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 3'd0, 4'd0, 21'd0, 6'd0}},
        '{32'h54800000, 1'b1,
          '{1'b1, 6'd31, 5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 3'd0, 4'd0, 21'h100000, 6'd0}},
        '{32'h547fffef, 1'b1,
          '{1'b1, 6'd31, 5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 3'd0, 4'd15, 21'h0ffffc, 6'd0}},
        '{32'h54000010, 1'b1,
          '{1'b1, 6'd31, 5'd0, 5'd0, 5'd0, 5'd0, 2'd0, 3'd0, 4'd0, 21'd0, 6'd0}},
        '{32'hd65f03c0, 1'b1,
          '{1'b1, 6'd32, 5'd0, 5'd30, 5'd0, 5'd0, 2'd0, 3'd0, 4'd0, 21'd0, 6'd0}},
        '{32'hd65f03c1, 1'b1, '0},
        '{32'hb8500400, 1'b0, '0},
        '{32'hb85ff7ff, 1'b0, '0},
        '{32'hb8100fe1, 1'b0, '0},
        '{32'h387f5bff, 1'b0, '0},
        '{32'h78605800, 1'b0, '0},
        '{32'hf8605800, 1'b0, '0},
        '{32'hcb3fffff, 1'b0, '0},
        '{32'h91c00000, 1'b0, '0},
        '{32'h72ffffff, 1'b0, '0},
        '{32'h5a9ff3ff, 1'b0, '0},
        '{32'h1b1f7fff, 1'b0, '0},
        '{32'h9b3f7fff, 1'b0, '0},
        '{32'h139ffc00, 1'b0, '0},
        '{32'hd37fffff, 1'b0, '0},
        '{32'h2a3fffff, 1'b0, '0}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    word_t                    instr_word = '0;
    logic                     busy;
    logic                     done;
    logic                     matched;
    logic [IDX_W-1:0]         form_index;
    logic [REG_W-1:0]         dest_reg;
    logic [REG_W-1:0]         first_src_reg;
    logic [REG_W-1:0]         second_src_reg;
    logic [REG_W-1:0]         addend_reg;
    logic [1:0]               shift_type;
    logic [2:0]               extend_option;
    logic [3:0]               cond_code;
    logic signed [PRIM_W-1:0] primary_imm;
    logic [SEC_W-1:0]         secondary_imm;

    decode_result_t pending_decodes [$];
    int             mismatches = 0;
    int             burst_left = 0;

    aarch64_subset_instruction_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .instr_word     (instr_word),
        .done           (done),
        .matched        (matched),
        .form_index     (form_index),
        .dest_reg       (dest_reg),
        .first_src_reg  (first_src_reg),
        .second_src_reg (second_src_reg),
        .addend_reg     (addend_reg),
        .shift_type     (shift_type),
        .extend_option  (extend_option),
        .cond_code      (cond_code),
        .primary_imm    (primary_imm),
        .secondary_imm  (secondary_imm)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic decode_result_t decode_word(input word_t w);
        decode_result_t r;
        decode_form_t   hit_form;
        int             hit;
        r = '0;
        hit = -1;
        for (int i = 0; i < NUM_FORMS; i++)
        begin
            if (hit < 0 && (w & FORM_TABLE[i].mask) == FORM_TABLE[i].value)
                hit = i;
        end
        if (hit < 0)
            return r;
        hit_form = FORM_TABLE[hit];
        r.matched    = 1'b1;
        r.form_index = IDX_W'(hit);
        if (hit_form.uses.rd)
            r.dest_reg = w[4:0];
        if (hit_form.uses.rn)
            r.first_src_reg = w[9:5];
        if (hit_form.uses.rm)
            r.second_src_reg = w[20:16];
        if (hit_form.uses.ra)
            r.addend_reg = w[14:10];
        if (hit_form.uses.sh)
            r.shift_type = w[23:22];
        if (hit_form.uses.ex)
            r.extend_option = w[15:13];
        if (hit_form.uses.cch)
            r.cond_code = w[15:12];
        if (hit_form.uses.ccl)
            r.cond_code = w[3:0];
        case (hit_form.pkind)
            P_IMM12: r.primary_imm = PRIM_W'(w[21:10]);
            P_AMT6:  r.primary_imm = PRIM_W'(w[15:10]);
            P_IMM16: r.primary_imm = PRIM_W'(w[20:5]);
            P_SIMM9: r.primary_imm = {{(PRIM_W-9){w[20]}}, w[20:12]};
            P_IMMR:  r.primary_imm = PRIM_W'(w[21:16]);
            P_BR:    r.primary_imm = {w[23:5], 2'b00};
            default: r.primary_imm = '0;
        endcase
        case (hit_form.skind)
            S_SH12:    r.secondary_imm = SEC_W'(w[23:22]) * SEC_W'(12);
            S_HW16:    r.secondary_imm = SEC_W'(w[22:21]) * SEC_W'(16);
            S_IMMS:    r.secondary_imm = w[15:10];
            S_BIT12X2: r.secondary_imm = w[12] ? SEC_W'(2) : '0;
            S_BIT12X3: r.secondary_imm = w[12] ? SEC_W'(3) : '0;
            S_BIT12X1: r.secondary_imm = SEC_W'(w[12]);
            S_EXT3:    r.secondary_imm = SEC_W'(w[12:10]);
            default:   r.secondary_imm = '0;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic issue_decode(input word_t w, input decode_result_t want);
        start      <= 1'b1;
        instr_word <= w;
        do
            @(posedge clk);
        while (busy);
        pending_decodes.push_back(want);
    endtask

    // bursts of back-to-back transactions, separated by random gaps when allow_idle is set
    task automatic pace(input bit allow_idle);
        int idle;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (allow_idle && idle > 0)
            begin
                start <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        decode_result_t got;
        decode_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            got = '{matched, form_index, dest_reg, first_src_reg, second_src_reg, addend_reg,
                    shift_type, extend_option, cond_code, primary_imm, secondary_imm};
            if (pending_decodes.size() == 0)
            begin
                $display("%0t: result with no transaction pending, expected none actual 0x%0h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                compare_field("matched", want.matched, got.matched);
                compare_field("form_index", want.form_index, got.form_index);
                compare_field("dest_reg", want.dest_reg, got.dest_reg);
                compare_field("first_src_reg", want.first_src_reg, got.first_src_reg);
                compare_field("second_src_reg", want.second_src_reg, got.second_src_reg);
                compare_field("addend_reg", want.addend_reg, got.addend_reg);
                compare_field("shift_type", want.shift_type, got.shift_type);
                compare_field("extend_option", want.extend_option, got.extend_option);
                compare_field("cond_code", want.cond_code, got.cond_code);
                compare_field("primary_imm", want.primary_imm, got.primary_imm);
                compare_field("secondary_imm", want.secondary_imm, got.secondary_imm);
            end
        end
    end

    initial
    begin : stimulus
        word_t w;
        int    f;
        int    b;
        int    pick;
        int    wait_cycles;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue_decode(DIRECTED[i].word,
                         DIRECTED[i].known ? DIRECTED[i].want : decode_word(DIRECTED[i].word));
            pace(1'b1);
        end
        // mostly well-formed words with random operands, some near misses and raw noise
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 9);
            f = $urandom_range(0, NUM_FORMS - 1);
            w = (FORM_TABLE[f].value & FORM_TABLE[f].mask) | ($urandom() & ~FORM_TABLE[f].mask);
            if (pick == 0)
            begin
                do
                    b = $urandom_range(0, 31);
                while (!FORM_TABLE[f].mask[b]);
                w[b] = ~w[b];
            end
            else if (pick < 3)
                w = $urandom();
            issue_decode(w, decode_word(w));
            pace(n < 500 || n >= 700);
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_decodes.size() != 0 && wait_cycles < 64)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_decodes.size() != 0)
        begin
            $display("%0t: expected %0d more results, actual none", $time,
                     pending_decodes.size());
            mismatches++;
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/aisd_pkg.sv
design/aarch64_subset_instruction_decoder.sv
test/tb_aarch64_subset_instruction_decoder.sv
